// ===== rtl/bgr_pkg.sv =====
// Shared types, field widths and codes for the bilinear gray resize block.
// Used by every module under rtl; depends on nothing else.
package bgr_pkg;

   localparam int SRC_W   = 7;
   localparam int TGT_W   = 11;
   localparam int COORD_W = 10;
   localparam int PIX_W   = 8;
   localparam int LADDR_W = 12;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam int FRAC_W = 8;
   localparam int POS_W  = SRC_W;
   localparam int NUM_W  = COORD_W + SRC_W;
   localparam int DVD_W  = NUM_W + FRAC_W;
   localparam int QUO_W  = POS_W + FRAC_W;
   localparam int DEN_W  = TGT_W;
   localparam int IDX_W  = 2 * SRC_W;
   localparam int WGT_W  = 2 * (FRAC_W + 1) - 1;
   localparam int ACC_W  = PIX_W + 2 * FRAC_W;

   localparam int MAX_TARGET_DIM = 1024;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_W = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_H = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TGT_W = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TGT_H = 3'd3;

   localparam logic [SRC_W-1:0] RST_SRC_W = 7'd20;
   localparam logic [SRC_W-1:0] RST_SRC_H = 7'd40;
   localparam logic [TGT_W-1:0] RST_TGT_W = 11'd16;
   localparam logic [TGT_W-1:0] RST_TGT_H = 11'd32;

   typedef struct packed {
      logic       capture;
      logic       div_step;
      logic       base_en;
      logic       rd_issue;
      logic [1:0] rd_sel;
      logic       acc_en;
      logic       out_load;
   } bgr_cmd_type;

   typedef struct packed {
      logic start_compute;
      logic out_free;
   } bgr_status_type;

endpackage

// ===== rtl/bgr_div.sv =====
// Restoring divider for coordinate mapping; one quotient bit per step cycle.
// Depends on bgr_pkg for the dividend, divisor and quotient widths.
module bgr_div (
   input  logic                      clock,
   input  logic                      load,
   input  logic                      step,
   input  logic [bgr_pkg::DVD_W-1:0] dividend,
   input  logic [bgr_pkg::DEN_W-1:0] divisor,
   output logic [bgr_pkg::QUO_W-1:0] quotient
);
   import bgr_pkg::*;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // The quotient is known to fit in QUO_W bits, so the leading dividend
   // bits are already a valid partial remainder.
   always_comb begin
      trial  = {rem_ff, quo_ff[QUO_W-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = DEN_W'(dividend[DVD_W-1:QUO_W]);
         quo_in = dividend[QUO_W-1:0];
      end else if (step) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

// ===== rtl/bgr_datapath.sv =====
// Datapath: size registers, frame store, two coordinate dividers, blend
// accumulator and result register. Depends on bgr_pkg and bgr_div.
module bgr_datapath #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [bgr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bgr_pkg::TGT_W-1:0]     csr_wdata,
   input  logic                          req_kind,
   input  logic [bgr_pkg::LADDR_W-1:0]   req_load_address,
   input  logic [bgr_pkg::PIX_W-1:0]     req_source_pixel,
   input  logic [bgr_pkg::COORD_W-1:0]   req_target_col,
   input  logic [bgr_pkg::COORD_W-1:0]   req_target_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bgr_pkg::PIX_W-1:0]     rsp_gray_out,
   output logic [bgr_pkg::STAT_W-1:0]    rsp_status,
   input  bgr_pkg::bgr_cmd_type          cmd,
   output bgr_pkg::bgr_status_type       status
);
   import bgr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   logic [SRC_W-1:0]  src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [TGT_W-1:0]  tgt_w_ff, tgt_w_in, tgt_h_ff, tgt_h_in;

   logic [PIX_W-1:0]  frame_store_ff [STORE_DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;

   logic [IDX_W-1:0]  area;
   logic              cfg_bad, coord_bad, addr_bad, start_compute;
   logic [STAT_W-1:0] code;

   logic              sample_ok_ff;
   logic [STAT_W-1:0] stat_ff;
   logic [DEN_W-1:0]  den_x_ff, den_y_ff;
   logic [NUM_W-1:0]  num_x, num_y;
   logic [QUO_W-1:0]  quo_x, quo_y;

   logic [POS_W-1:0]  pos_x, pos_y;
   logic [FRAC_W-1:0] frac_x, frac_y;
   logic [POS_W-1:0]  x_ff, x1_ff;
   logic [FRAC_W-1:0] fx_ff, fy_ff;
   logic [IDX_W-1:0]  row_ff;
   logic              y_step_ff;

   logic [IDX_W-1:0]  rd_idx;
   logic [FRAC_W:0]   wx, wy;
   logic [WGT_W-1:0]  wgt_in, wgt_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W:0]    rounded;
   logic [PIX_W-1:0]  gray;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_gray_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      tgt_w_in = tgt_w_ff;
      tgt_h_in = tgt_h_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SRC_W: src_w_in = csr_wdata[SRC_W-1:0];
            CSR_SRC_H: src_h_in = csr_wdata[SRC_W-1:0];
            CSR_TGT_W: tgt_w_in = csr_wdata;
            CSR_TGT_H: tgt_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= RST_SRC_W;
         src_h_ff <= RST_SRC_H;
         tgt_w_ff <= RST_TGT_W;
         tgt_h_ff <= RST_TGT_H;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         tgt_w_ff <= tgt_w_in;
         tgt_h_ff <= tgt_h_in;
      end
   end

   always_comb begin
      area      = IDX_W'(src_w_ff) * IDX_W'(src_h_ff);
      cfg_bad   = (src_w_ff < SRC_W'(2)) || (src_h_ff < SRC_W'(2)) ||
                  (tgt_w_ff == '0) || (tgt_h_ff == '0) ||
                  (32'(tgt_w_ff) > 32'(MAX_TARGET_DIM)) ||
                  (32'(tgt_h_ff) > 32'(MAX_TARGET_DIM)) ||
                  (32'(area) > 32'(STORE_DEPTH));
      coord_bad = ({1'b0, req_target_col} >= tgt_w_ff) ||
                  ({1'b0, req_target_row} >= tgt_h_ff);
      addr_bad  = !(32'(req_load_address) < 32'(STORE_DEPTH));
      start_compute = (req_kind == KIND_SAMPLE) && !cfg_bad && !coord_bad;
      if (req_kind == KIND_LOAD) begin
         code = addr_bad ? ST_RANGE : ST_OK;
      end else if (cfg_bad) begin
         code = ST_BAD_SIZE;
      end else begin
         code = coord_bad ? ST_RANGE : ST_OK;
      end
      num_x = NUM_W'(req_target_col) * NUM_W'(src_w_ff - SRC_W'(1));
      num_y = NUM_W'(req_target_row) * NUM_W'(src_h_ff - SRC_W'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ok_ff <= start_compute;
         stat_ff      <= code;
         den_x_ff     <= tgt_w_ff - TGT_W'(1);
         den_y_ff     <= tgt_h_ff - TGT_W'(1);
      end
   end

   bgr_div u_div_x (
      .clock    (clock),
      .load     (cmd.capture),
      .step     (cmd.div_step),
      .dividend ({num_x, {FRAC_W{1'b0}}}),
      .divisor  (den_x_ff),
      .quotient (quo_x)
   );

   bgr_div u_div_y (
      .clock    (clock),
      .load     (cmd.capture),
      .step     (cmd.div_step),
      .dividend ({num_y, {FRAC_W{1'b0}}}),
      .divisor  (den_y_ff),
      .quotient (quo_y)
   );

   // A destination size of one maps every point to the first pixel.
   always_comb begin
      pos_x  = (den_x_ff == '0) ? '0 : quo_x[QUO_W-1:FRAC_W];
      frac_x = (den_x_ff == '0) ? '0 : quo_x[FRAC_W-1:0];
      pos_y  = (den_y_ff == '0) ? '0 : quo_y[QUO_W-1:FRAC_W];
      frac_y = (den_y_ff == '0) ? '0 : quo_y[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.base_en) begin
         x_ff      <= pos_x;
         x1_ff     <= (pos_x == src_w_ff - SRC_W'(1)) ? pos_x : pos_x + POS_W'(1);
         fx_ff     <= frac_x;
         fy_ff     <= frac_y;
         row_ff    <= IDX_W'(pos_y) * IDX_W'(src_w_ff);
         y_step_ff <= pos_y != src_h_ff - SRC_W'(1);
      end
   end

   always_comb begin
      rd_idx = row_ff + ((cmd.rd_sel[1] && y_step_ff) ? IDX_W'(src_w_ff) : '0) +
               IDX_W'(cmd.rd_sel[0] ? x1_ff : x_ff);
      wx     = cmd.rd_sel[0] ? {1'b0, fx_ff} : (FRAC_W+1)'(256) - {1'b0, fx_ff};
      wy     = cmd.rd_sel[1] ? {1'b0, fy_ff} : (FRAC_W+1)'(256) - {1'b0, fy_ff};
      wgt_in = WGT_W'(wx) * WGT_W'(wy);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && (req_kind == KIND_LOAD) && !addr_bad) begin
         frame_store_ff[ADDR_W'(req_load_address)] <= req_source_pixel;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= frame_store_ff[ADDR_W'(rd_idx)];
         wgt_ff     <= wgt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(ACC_W'(rd_data_ff) * ACC_W'(wgt_ff));
      end
   end

   always_comb begin
      rounded      = {1'b0, acc_ff} + (ACC_W+1)'(32768);
      gray         = rounded[ACC_W] ? '1 : rounded[ACC_W-1:2*FRAC_W];
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_gray_ff   <= sample_ok_ff ? gray : '0;
         rsp_status_ff <= stat_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_gray_out         = rsp_gray_ff;
   assign rsp_status           = rsp_status_ff;
   assign status.start_compute = start_compute;
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Result register loaded while holding an untaken item.");

   a_read_in_store: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> (32'(rd_idx) < 32'(STORE_DEPTH)))
      else $error("Neighbour index beyond the frame store.");

endmodule

// ===== rtl/bgr_ctrl.sv =====
// Controller state machine: sequences capture, division, neighbour reads,
// blending and result hand-off. Depends on bgr_pkg for command and status.
module bgr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output bgr_pkg::bgr_cmd_type    cmd,
   input  bgr_pkg::bgr_status_type status
);
   import bgr_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_BASE = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_LAST = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
   localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(3);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = status.start_compute ? S_DIV : S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_BASE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_BASE: begin
            cmd.base_en = 1'b1;
            cnt_in      = '0;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = cnt_ff[1:0];
            cmd.acc_en   = cnt_ff != '0;
            if (cnt_ff == READ_LAST) begin
               state_in = S_LAST;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_LAST: begin
            cmd.acc_en = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_short_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !status.start_compute) |=> state_ff == S_DONE)
      else $error("An item needing no blend did not go straight to hand-off.");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == DIV_LAST) |=> state_ff == S_BASE)
      else $error("Division did not end after its last quotient bit.");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff <= DIV_LAST)
      else $error("Division step count overran.");

endmodule

// ===== rtl/bilinear_gray_resize.sv =====
// Top level of the bilinear grayscale resize block.
// Depends on bgr_pkg, bgr_ctrl and bgr_datapath (which holds bgr_div).
//
//   Channel  Ports                                           Direction
//   req      req_valid/req_stall, kind, address, pixel,      in
//            target column and row
//   rsp      rsp_valid/rsp_stall, gray_out, status           out
//   csr      csr_write, csr_index, csr_wdata                 in
//
// A load item, or a sample item with bad sizes or coordinates, goes from capture
// straight to the result hand-off. A valid sample item passes through capture,
// 15 steps of the two parallel dividers, the row base, four frame store reads,
// the last blend accumulation, and the load of the result register.
// Reset is synchronous; the frame store has no reset and holds junk until loaded.
// A waiting result does not block acceptance of the next item; a stalled
// result only holds back the hand-off of the following one.
module bilinear_gray_resize #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [bgr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bgr_pkg::TGT_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [bgr_pkg::LADDR_W-1:0]   req_load_address,
   input  logic [bgr_pkg::PIX_W-1:0]     req_source_pixel,
   input  logic [bgr_pkg::COORD_W-1:0]   req_target_col,
   input  logic [bgr_pkg::COORD_W-1:0]   req_target_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bgr_pkg::PIX_W-1:0]     rsp_gray_out,
   output logic [bgr_pkg::STAT_W-1:0]    rsp_status
);
   import bgr_pkg::*;

   bgr_cmd_type    cmd;
   bgr_status_type status;

   bgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bgr_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_load_address (req_load_address),
      .req_source_pixel (req_source_pixel),
      .req_target_col   (req_target_col),
      .req_target_row   (req_target_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gray_out     (rsp_gray_out),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
